@@ rtl/drp_pkg.sv @@
// ----------------------------------------------------------------------------
// drp_pkg
// Types and fixed constants shared by the disparity reprojection core.
// ----------------------------------------------------------------------------
package drp_pkg;

   localparam int NUM_PAIRS = 8;
   localparam int NUM_COEFS = 16;
   localparam int ACC_W     = 55;
   localparam int MAG_W     = 55;
   localparam int QUOT_W    = 32;
   localparam int FRAC_W    = 16;

   typedef struct packed {
      logic [11:0] pixel_u;
      logic [11:0] pixel_v;
      logic [15:0] disparity;
      logic [7:0]  mask_value;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               w_zero;
      logic [7:0]         red_out;
      logic [7:0]         green_out;
      logic [7:0]         blue_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

endpackage

@@ rtl/drp_mac.sv @@
// ----------------------------------------------------------------------------
// drp_mac
// Two-stage matrix multiply: registered products, then registered row sums.
// ----------------------------------------------------------------------------
module drp_mac #(
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [COORD_BITS-1:0]               u,
   input  logic [COORD_BITS-1:0]               v,
   input  logic [15:0]                         d,
   input  logic [drp_pkg::NUM_COEFS-1:0][31:0] coef,
   output logic signed [drp_pkg::ACC_W-1:0]    acc [4]
);

   localparam int UP_W = COORD_BITS + 37;
   localparam int DP_W = 49;

   logic signed [UP_W-1:0]          pu_ff [4];
   logic signed [UP_W-1:0]          pv_ff [4];
   logic signed [DP_W-1:0]          pd_ff [4];
   logic signed [31:0]              pc_ff [4];
   logic signed [drp_pkg::ACC_W-1:0] acc_ff [4];

   logic signed [COORD_BITS+4:0] u16;
   logic signed [COORD_BITS+4:0] v16;
   logic signed [16:0]           dd;

   assign u16 = $signed({1'b0, u, 4'b0000});
   assign v16 = $signed({1'b0, v, 4'b0000});
   assign dd  = $signed({1'b0, d});

   for (genvar r = 0; r < 4; r++) begin : g_row
      logic signed [UP_W-1:0] pu_in;
      logic signed [UP_W-1:0] pv_in;
      logic signed [DP_W-1:0] pd_in;
      logic signed [drp_pkg::ACC_W-1:0] acc_in;

      assign pu_in = $signed(coef[4*r]) * u16;
      assign pv_in = $signed(coef[4*r+1]) * v16;
      assign pd_in = $signed(coef[4*r+2]) * dd;
      assign acc_in = drp_pkg::ACC_W'(pu_ff[r]) + drp_pkg::ACC_W'(pv_ff[r])
                    + drp_pkg::ACC_W'(pd_ff[r])
                    + (drp_pkg::ACC_W'(pc_ff[r]) <<< 4);

      always_ff @(posedge clock) begin
         if (advance) begin
            pu_ff[r]  <= pu_in;
            pv_ff[r]  <= pv_in;
            pd_ff[r]  <= pd_in;
            pc_ff[r]  <= $signed(coef[4*r+3]);
            acc_ff[r] <= acc_in;
         end
      end

      assign acc[r] = acc_ff[r];
   end

endmodule

@@ rtl/drp_divider.sv @@
// ----------------------------------------------------------------------------
// drp_divider
// Pipelined restoring divider, one quotient bit per stage, with rounding and
// saturation to signed Q16.16 after the last stage.
// ----------------------------------------------------------------------------
module drp_divider (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [drp_pkg::MAG_W-1:0]   n_in,
   input  logic [drp_pkg::MAG_W-1:0]   dm_in,
   input  logic                        neg_in,
   input  logic                        ovf_in,
   output logic [drp_pkg::QUOT_W-1:0]  quot_out
);

   localparam int MW = drp_pkg::MAG_W;
   localparam int QW = drp_pkg::QUOT_W;
   localparam int FW = drp_pkg::FRAC_W;

   logic [MW-1:0] r_ff   [QW];
   logic [FW-1:0] nlo_ff [QW];
   logic [MW-1:0] dm_ff  [QW];
   logic [QW-1:0] q_ff   [QW];
   logic          neg_ff [QW];
   logic          ovf_ff [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [MW-1:0] rp;
      logic [FW-1:0] lp;
      logic [MW-1:0] dp;
      logic [QW-1:0] qp;
      logic          sp;
      logic          op;
      logic [MW:0]   t;
      logic [MW:0]   diff;
      logic          ge;
      logic [MW-1:0] r_in;

      if (i == 0) begin : g_first
         assign rp = n_in >> FW;
         assign lp = n_in[FW-1:0];
         assign dp = dm_in;
         assign qp = '0;
         assign sp = neg_in;
         assign op = ovf_in;
      end else begin : g_next
         assign rp = r_ff[i-1];
         assign lp = nlo_ff[i-1];
         assign dp = dm_ff[i-1];
         assign qp = q_ff[i-1];
         assign sp = neg_ff[i-1];
         assign op = ovf_ff[i-1];
      end

      assign t    = {rp, lp[FW-1]};
      assign diff = t - {1'b0, dp};
      assign ge   = t >= {1'b0, dp};
      assign r_in = ge ? diff[MW-1:0] : t[MW-1:0];

      always_ff @(posedge clock) begin
         if (advance) begin
            r_ff[i]   <= r_in;
            nlo_ff[i] <= {lp[FW-2:0], 1'b0};
            dm_ff[i]  <= dp;
            q_ff[i]   <= {qp[QW-2:0], ge};
            neg_ff[i] <= sp;
            ovf_ff[i] <= op;
         end
      end
   end

   logic          round_up;
   logic [QW:0]   qq;

   assign round_up = {r_ff[QW-1], 1'b0} >= {1'b0, dm_ff[QW-1]};
   assign qq       = {1'b0, q_ff[QW-1]} + {{QW{1'b0}}, round_up};

   always_comb begin
      if (ovf_ff[QW-1]) begin
         quot_out = neg_ff[QW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else if (neg_ff[QW-1]) begin
         if (qq >= {2'b01, {(QW-1){1'b0}}}) begin
            quot_out = {1'b1, {(QW-1){1'b0}}};
         end else begin
            quot_out = QW'(-qq);
         end
      end else begin
         if (qq > {2'b00, {(QW-1){1'b1}}}) begin
            quot_out = {1'b0, {(QW-1){1'b1}}};
         end else begin
            quot_out = qq[QW-1:0];
         end
      end
   end

endmodule

@@ rtl/disparity_to_point_reproject_core.sv @@
// ----------------------------------------------------------------------------
// disparity_to_point_reproject_core
// Reprojects a disparity pixel to a 3-D point with a 4x4 matrix.
// ----------------------------------------------------------------------------
// The core takes one item per clock unless the output is stalled. Each result
// passes the matrix-multiply product and row-sum registers, the magnitude and
// overflow preparation register, the bit-per-stage divider stages and the
// output register. Items with a zero mask or zero disparity are dropped at the
// input. The whole pipeline holds while a result waits on rsp_stall.
module disparity_to_point_reproject_core #(
   parameter int COORD_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  drp_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output drp_pkg::rsp_type rsp_item,
   input  logic             csr_write_enable,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_write_data
);

   localparam int MW    = drp_pkg::MAG_W;
   localparam int QW    = drp_pkg::QUOT_W;
   localparam int DEPTH = QW + 3;

   logic [63:0] q_pair_ff [drp_pkg::NUM_PAIRS];
   logic [drp_pkg::NUM_COEFS-1:0][31:0] coef;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < drp_pkg::NUM_PAIRS; i++) begin
            q_pair_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         q_pair_ff[csr_index] <= csr_write_data;
      end
   end

   for (genvar k = 0; k < drp_pkg::NUM_COEFS; k++) begin : g_coef
      assign coef[k] = q_pair_ff[k/2][32*(k%2) +: 32];
   end

   logic             advance;
   logic             take;
   logic             rsp_valid_ff;
   drp_pkg::rsp_type rsp_item_ff;
   logic             valid_ff [DEPTH];
   drp_pkg::color_type color_ff [DEPTH];
   logic             wz_ff [DEPTH];

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign take      = req_valid && (req_item.mask_value != 8'd0)
                    && (req_item.disparity != 16'd0);

   logic signed [drp_pkg::ACC_W-1:0] acc [4];

   drp_mac #(
      .COORD_BITS(COORD_BITS)
   ) u_mac (
      .clock  (clock),
      .advance(advance),
      .u      (COORD_BITS'(req_item.pixel_u)),
      .v      (COORD_BITS'(req_item.pixel_v)),
      .d      (req_item.disparity),
      .coef   (coef),
      .acc    (acc)
   );

   logic [MW-1:0] mag_in [4];
   logic [MW-1:0] mag_ff [4];
   logic          neg_ff [3];
   logic          ovf_ff [3];

   for (genvar r = 0; r < 4; r++) begin : g_mag
      assign mag_in[r] = acc[r][drp_pkg::ACC_W-1] ? MW'(-acc[r]) : MW'(acc[r]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 4; r++) begin
            mag_ff[r] <= mag_in[r];
         end
         for (int r = 0; r < 3; r++) begin
            neg_ff[r] <= acc[r][drp_pkg::ACC_W-1] ^ acc[3][drp_pkg::ACC_W-1];
            ovf_ff[r] <= {{drp_pkg::FRAC_W{1'b0}}, mag_in[r]}
                         >= {mag_in[3], {drp_pkg::FRAC_W{1'b0}}};
         end
      end
   end

   logic [QW-1:0] quot [3];

   for (genvar r = 0; r < 3; r++) begin : g_div
      drp_divider u_div (
         .clock   (clock),
         .advance (advance),
         .n_in    (mag_ff[r]),
         .dm_in   (mag_ff[3]),
         .neg_in  (neg_ff[r]),
         .ovf_in  (ovf_ff[r]),
         .quot_out(quot[r])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= take;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff[0] <= '{red: req_item.red_in, green: req_item.green_in,
                          blue: req_item.blue_in};
         wz_ff[0]    <= 1'b0;
         for (int i = 1; i < DEPTH; i++) begin
            color_ff[i] <= color_ff[i-1];
            if (i == 2) begin
               wz_ff[i] <= (acc[3] == '0);
            end else begin
               wz_ff[i] <= wz_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff.w_zero    <= wz_ff[DEPTH-1];
         rsp_item_ff.point_x   <= wz_ff[DEPTH-1] ? '0 : $signed(quot[0]);
         rsp_item_ff.point_y   <= wz_ff[DEPTH-1] ? '0 : $signed(quot[1]);
         rsp_item_ff.point_z   <= wz_ff[DEPTH-1] ? '0 : $signed(quot[2]);
         rsp_item_ff.red_out   <= color_ff[DEPTH-1].red;
         rsp_item_ff.green_out <= color_ff[DEPTH-1].green;
         rsp_item_ff.blue_out  <= color_ff[DEPTH-1].blue;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_stall_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("Input stall does not follow the output register.");

   a_skip_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_item.mask_value == 8'd0)) |=> !valid_ff[0])
      else $error("A masked item entered the pipeline.");

   a_wzero_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.w_zero) |->
         (rsp_item.point_x == 0 && rsp_item.point_y == 0 && rsp_item.point_z == 0))
      else $error("Zero W result carries nonzero coordinates.");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid_ff[DEPTH-1]))
      else $error("Pipeline moved while the output was stalled.");

endmodule
